@@ design/sensor_frame_check_thermostat_top_assert.svh @@
// Assertion macros for the thermostat front end.
`ifndef SENSOR_FRAME_CHECK_THERMOSTAT_TOP_ASSERT_SVH
`define SENSOR_FRAME_CHECK_THERMOSTAT_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SFCT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfct assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define SFCT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfct assertion failed");

`endif

@@ design/sfct_pkg.sv @@
package sfct_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_STEP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HYST = 2'd2;

    localparam logic signed [14:0] BASE_RESET = 15'sd2000;
    localparam logic [7:0]         STEP_RESET = 8'd98;
    localparam logic [10:0]        HYST_RESET = 11'd100;

    localparam logic [3:0]  FRAME_LAST_POS = 4'd8;
    localparam logic [7:0]  CRC_POLY       = 8'h8C;

    // Division by ten as multiplication by ceil(2^19 / 10), exact for 16-bit operands.
    localparam logic [16:0] RECIP_TEN   = 17'd52429;
    localparam int          RECIP_SHIFT = 19;

    typedef enum logic [1:0] {
        STATUS_GOOD         = 2'd0,
        STATUS_NO_PRESENCE  = 2'd1,
        STATUS_CRC_MISMATCH = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [14:0] base;
        logic [7:0]         step;
        logic [10:0]        hyst;
    } t_cfg;

    typedef struct packed {
        logic        valid;
        t_status     status;
        logic [7:0]  low_byte;
        logic [7:0]  high_byte;
        logic [15:0] knob_prod;
    } t_check;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        logic       fb;
        c = crc;
        for (int k = 0; k < 8; k++) begin
            fb = c[0] ^ data[k];
            c  = {1'b0, c[7:1]};
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    // Sixteenths of a degree expressed in hundredths, truncated.
    function automatic logic [6:0] frac_hundredths(input logic [3:0] nib);
        logic [6:0] v;
        case (nib)
            4'd0:    v = 7'd0;
            4'd1:    v = 7'd6;
            4'd2:    v = 7'd12;
            4'd3:    v = 7'd18;
            4'd4:    v = 7'd25;
            4'd5:    v = 7'd31;
            4'd6:    v = 7'd37;
            4'd7:    v = 7'd43;
            4'd8:    v = 7'd50;
            4'd9:    v = 7'd56;
            4'd10:   v = 7'd62;
            4'd11:   v = 7'd68;
            4'd12:   v = 7'd75;
            4'd13:   v = 7'd81;
            4'd14:   v = 7'd87;
            4'd15:   v = 7'd93;
            default: v = 7'd0;
        endcase
        return v;
    endfunction

endpackage

@@ design/sfct_in_if.sv @@
interface sfct_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] data_byte;
    logic [7:0] knob;

    modport source (output valid, output mode, output data_byte, output knob, input ready);
    modport sink   (input valid, input mode, input data_byte, input knob, output ready);
endinterface

@@ design/sfct_out_if.sv @@
interface sfct_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [14:0] temperature;
    logic               heater;

    modport source (output valid, output status, output temperature, output heater, input ready);
    modport sink   (input valid, input status, input temperature, input heater, output ready);
endinterface

@@ design/sfct_cfg_if.sv @@
interface sfct_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [sfct_pkg::CFG_IDX_W-1:0]  index;
    logic [sfct_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/sfct_cfg_regs.sv @@
module sfct_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sfct_cfg_if.sink      i_cfg,
    output sfct_pkg::t_cfg o_cfg
);

    sfct_pkg::t_cfg r_cfg;
    sfct_pkg::t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            case (i_cfg.index)
                sfct_pkg::CFG_IDX_BASE: n_cfg.base = $signed(i_cfg.data[14:0]);
                sfct_pkg::CFG_IDX_STEP: n_cfg.step = i_cfg.data[7:0];
                sfct_pkg::CFG_IDX_HYST: n_cfg.hyst = i_cfg.data[10:0];
                default:                n_cfg      = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base <= sfct_pkg::BASE_RESET;
            r_cfg.step <= sfct_pkg::STEP_RESET;
            r_cfg.hyst <= sfct_pkg::HYST_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

@@ design/sfct_frame.sv @@
module sfct_frame (
    input  logic            i_clk,
    input  logic            i_rst_n,
    sfct_in_if.sink         i_in,
    input  sfct_pkg::t_cfg  i_cfg,
    input  logic            i_take,
    output sfct_pkg::t_check o_check
);

    logic        r_s1_valid;
    logic        r_mode;
    logic [7:0]  r_byte;
    logic [15:0] r_prod;
    logic [3:0]  r_pos;
    logic [7:0]  r_crc;
    logic [7:0]  r_low;
    logic [7:0]  r_high;

    logic        n_s1_valid;
    logic [3:0]  n_pos;
    logic [7:0]  n_crc;
    logic [7:0]  n_low;
    logic [7:0]  n_high;

    logic        has_result;
    logic        fire;
    logic        accept;

    assign has_result = r_mode || (r_pos >= sfct_pkg::FRAME_LAST_POS);
    assign fire       = r_s1_valid && (!has_result || i_take);
    assign i_in.ready = !r_s1_valid || fire;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        o_check.valid     = r_s1_valid && has_result;
        o_check.low_byte  = r_low;
        o_check.high_byte = r_high;
        o_check.knob_prod = r_prod;
        if (r_mode) begin
            o_check.status = sfct_pkg::STATUS_NO_PRESENCE;
        end else if (r_byte != r_crc) begin
            o_check.status = sfct_pkg::STATUS_CRC_MISMATCH;
        end else begin
            o_check.status = sfct_pkg::STATUS_GOOD;
        end
    end

    always_comb begin
        n_s1_valid = accept || (r_s1_valid && !fire);
        n_pos      = r_pos;
        n_crc      = r_crc;
        n_low      = r_low;
        n_high     = r_high;
        if (fire) begin
            if (has_result) begin
                n_pos = '0;
                n_crc = '0;
            end else begin
                if (r_pos == 4'd0) begin
                    n_low = r_byte;
                end
                if (r_pos == 4'd1) begin
                    n_high = r_byte;
                end
                n_crc = sfct_pkg::crc8_update(r_crc, r_byte);
                n_pos = r_pos + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_pos      <= '0;
            r_crc      <= '0;
            r_low      <= '0;
            r_high     <= '0;
        end else begin
            r_s1_valid <= n_s1_valid;
            r_pos      <= n_pos;
            r_crc      <= n_crc;
            r_low      <= n_low;
            r_high     <= n_high;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode <= i_in.mode;
            r_byte <= i_in.data_byte;
            r_prod <= i_in.knob * i_cfg.step;
        end
    end

endmodule

@@ design/sfct_heater.sv @@
module sfct_heater (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sfct_pkg::t_cfg   i_cfg,
    input  sfct_pkg::t_check i_check,
    output logic             o_take,
    sfct_out_if.source       o_out
);

    logic               r_out_valid;
    logic [1:0]         r_status;
    logic signed [14:0] r_temp;
    logic               r_heater_out;
    logic               r_heater_on;

    logic               n_heater_on;

    logic               load;
    logic [15:0]        word;
    logic               neg;
    logic [15:0]        w_abs;
    logic [13:0]        mag;
    logic signed [14:0] temp;
    logic [32:0]        recip_prod;
    logic [12:0]        quot;
    logic signed [16:0] target;
    logic signed [16:0] lower;
    logic signed [16:0] upper;
    logic signed [16:0] temp_ext;
    logic               good;

    assign o_take = !r_out_valid || o_out.ready;
    assign load   = i_check.valid && o_take;
    assign good   = (i_check.status == sfct_pkg::STATUS_GOOD);

    always_comb begin
        word     = {i_check.high_byte, i_check.low_byte};
        neg      = i_check.high_byte[7];
        w_abs    = neg ? (~word + 16'd1) : word;
        mag      = 14'({7'd0, w_abs[10:4]} * 14'd100)
                 + {7'd0, sfct_pkg::frac_hundredths(w_abs[3:0])};
        temp     = neg ? $signed(~{1'b0, mag} + 15'd1) : $signed({1'b0, mag});
        temp_ext = {{2{temp[14]}}, temp};

        recip_prod = {17'd0, i_check.knob_prod} * {16'd0, sfct_pkg::RECIP_TEN};
        quot       = recip_prod[sfct_pkg::RECIP_SHIFT +: 13];
        target     = {{2{i_cfg.base[14]}}, i_cfg.base} + $signed({4'd0, quot});
        lower      = target - $signed({6'd0, i_cfg.hyst});
        upper      = target + $signed({6'd0, i_cfg.hyst});
    end

    always_comb begin
        n_heater_on = r_heater_on;
        if (load) begin
            if (!good) begin
                n_heater_on = 1'b0;
            end else begin
                if (temp_ext < lower) begin
                    n_heater_on = 1'b1;
                end
                if (temp_ext > upper) begin
                    n_heater_on = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_heater_on <= 1'b0;
        end else begin
            r_out_valid <= load || (r_out_valid && !o_out.ready);
            r_heater_on <= n_heater_on;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_status     <= i_check.status;
            r_temp       <= good ? temp : '0;
            r_heater_out <= n_heater_on;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_status;
    assign o_out.temperature = r_temp;
    assign o_out.heater      = r_heater_out;

endmodule

@@ design/sensor_frame_check_thermostat_top.sv @@
// Channel    Direction  Payload
// i_in       in         mode, data_byte, knob
// o_out      out        status, temperature, heater
// i_cfg      in         index, data (0 base, 1 step, 2 hysteresis)
//
// One item is accepted per cycle while the input is not stalled.
// Each byte passes an input register and the CRC logic; a completing item then goes through
// decode and setpoint logic into the output register, which holds the result until taken.
// Reset is synchronous and active low and restores the frame, heater and registers.
// Input stalls only while a completing item waits behind an untaken result.
`include "sensor_frame_check_thermostat_top_assert.svh"

module sensor_frame_check_thermostat_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sfct_in_if.sink     i_in,
    sfct_out_if.source  o_out,
    sfct_cfg_if.sink    i_cfg
);

    sfct_pkg::t_cfg   cfg;
    sfct_pkg::t_check check;
    logic             take;

    sfct_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    sfct_frame u_frame (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (cfg),
        .i_take  (take),
        .o_check (check)
    );

    sfct_heater u_heater (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_check (check),
        .o_take  (take),
        .o_out   (o_out)
    );

    `SFCT_ASSERT_NEXT(a_result_lands, i_clk, i_rst_n, check.valid && take, o_out.valid)
    `SFCT_ASSERT_SAME(a_error_clears, i_clk, i_rst_n, o_out.valid && (o_out.status != 2'(sfct_pkg::STATUS_GOOD)), (o_out.temperature == '0) && !o_out.heater)
    `SFCT_ASSERT_SAME(a_stall_when_full, i_clk, i_rst_n, !i_in.ready, o_out.valid && !o_out.ready)

endmodule

@@ sim/sfct_checker.sv @@
`timescale 1ns / 1ps

package sfct_tb_pkg;

    function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] r;
        r = crc;
        for (int k = 0; k < 8; k++) begin
            r = (r[0] ^ b[k]) ? ((r >> 1) ^ sfct_pkg::CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

endpackage

module sfct_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    sfct_in_if   in_ch,
    sfct_out_if  out_ch,
    sfct_cfg_if  cfg_ch,
    output int   o_fails,
    output int   o_pending,
    output int   o_checked
);
    import sfct_pkg::*;
    import sfct_tb_pkg::*;

    typedef struct {
        t_status            status;
        logic signed [14:0] temperature;
        logic               heater;
    } t_reading;

    t_reading           readings[$];
    logic signed [14:0] base;
    logic [7:0]         step;
    logic [10:0]        hyst;
    logic [3:0]         pos;
    logic [7:0]         crc;
    logic [7:0]         lo;
    logic [7:0]         hi;
    logic               heat;
    int                 fails = 0;
    int                 checked = 0;

    function automatic int decode_hundredths(input logic [7:0] l, input logic [7:0] h);
        logic [15:0] w;
        int          mag;
        w = {h, l};
        if (h[7]) begin
            w = -w;
        end
        mag = int'(w[10:4]) * 100 + (int'(w[3:0]) * 625) / 100;
        return h[7] ? -mag : mag;
    endfunction

    task automatic restart_with_error(input t_status s);
        t_reading r;
        pos  = 4'd0;
        crc  = 8'd0;
        heat = 1'b0;
        r.status      = s;
        r.temperature = 15'sd0;
        r.heater      = 1'b0;
        readings.push_back(r);
    endtask

    task automatic take_request(input logic m, input logic [7:0] b, input logic [7:0] k);
        t_reading r;
        int       t;
        int       target;
        if (m) begin
            restart_with_error(STATUS_NO_PRESENCE);
        end else if (pos < FRAME_LAST_POS) begin
            if (pos == 4'd0) begin
                lo = b;
            end else if (pos == 4'd1) begin
                hi = b;
            end
            crc = crc_fold(crc, b);
            pos = pos + 4'd1;
        end else if (b != crc) begin
            restart_with_error(STATUS_CRC_MISMATCH);
        end else begin
            pos = 4'd0;
            crc = 8'd0;
            t = decode_hundredths(lo, hi);
            target = int'(base) + (int'(k) * int'(step)) / 10;
            if (t < target - int'(hyst)) begin
                heat = 1'b1;
            end
            if (t > target + int'(hyst)) begin
                heat = 1'b0;
            end
            r.status      = STATUS_GOOD;
            r.temperature = t[14:0];
            r.heater      = heat;
            readings.push_back(r);
        end
    endtask

    always @(posedge i_clk) begin
        t_reading r;
        if (!i_rst_n) begin
            base = BASE_RESET;
            step = STEP_RESET;
            hyst = HYST_RESET;
            pos  = 4'd0;
            crc  = 8'd0;
            lo   = 8'd0;
            hi   = 8'd0;
            heat = 1'b0;
            readings.delete();
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.index)
                    CFG_IDX_BASE: base = cfg_ch.data;
                    CFG_IDX_STEP: step = cfg_ch.data[7:0];
                    CFG_IDX_HYST: hyst = cfg_ch.data[10:0];
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready) begin
                take_request(in_ch.mode, in_ch.data_byte, in_ch.knob);
            end
            if (out_ch.valid && out_ch.ready) begin
                if (readings.size() == 0) begin
                    $error("unexpected result: status %0d, temperature %0d, heater %0d",
                           out_ch.status, out_ch.temperature, out_ch.heater);
                    fails++;
                end else begin
                    r = readings.pop_front();
                    checked++;
                    if (out_ch.status !== r.status) begin
                        $error("status: expected %0d, actual %0d", r.status, out_ch.status);
                        fails++;
                    end
                    if (out_ch.temperature !== r.temperature) begin
                        $error("temperature: expected %0d, actual %0d",
                               r.temperature, out_ch.temperature);
                        fails++;
                    end
                    if (out_ch.heater !== r.heater) begin
                        $error("heater: expected %0d, actual %0d", r.heater, out_ch.heater);
                        fails++;
                    end
                end
            end
        end
        o_pending <= readings.size();
        o_fails   <= fails;
        o_checked <= checked;
    end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import sfct_pkg::*;
    import sfct_tb_pkg::*;

    localparam int STALL_LIMIT  = 5000;
    localparam int RANDOM_ITEMS = 650;
    localparam int CALM_FROM    = 300;
    localparam int CALM_LEN     = 120;

    typedef enum {FRAME_GOOD, FRAME_BAD_CRC, FRAME_CUT} t_frame_kind;

    logic i_clk;
    logic i_rst_n;
    logic calm;
    int   fails;
    int   pending;
    int   checked;
    int   items;
    int   frames_good;
    int   frames_bad;
    int   frames_cut;
    int   settings;
    int   stall;
    int   cur_base;
    int   cur_step;
    int   cur_hyst;

    sfct_in_if  in_ch ();
    sfct_out_if out_ch ();
    sfct_cfg_if cfg_ch ();

    sensor_frame_check_thermostat_top uut (
        .i_clk,
        .i_rst_n,
        .i_in  (in_ch),
        .o_out (out_ch),
        .i_cfg (cfg_ch)
    );

    sfct_checker u_check (
        .i_clk,
        .i_rst_n,
        .in_ch,
        .out_ch,
        .cfg_ch,
        .o_fails   (fails),
        .o_pending (pending),
        .o_checked (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        out_ch.ready <= calm || ($urandom_range(0, 99) >= 21);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            stall <= 0;
        end else if (stall >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            stall <= stall + 1;
        end
    end

    task automatic send_request(input logic m, input logic [7:0] b, input logic [7:0] k);
        if (!calm) begin
            while ($urandom_range(0, 99) < 21) begin
                in_ch.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        in_ch.valid     <= 1'b1;
        in_ch.mode      <= m;
        in_ch.data_byte <= b;
        in_ch.knob      <= k;
        do @(posedge i_clk); while (!in_ch.ready);
        items++;
    endtask

    task automatic send_frame(input logic [7:0] lo, input logic [7:0] hi,
                              input logic [7:0] knob_last, input t_frame_kind kind);
        logic [7:0] c;
        logic [7:0] b;
        int         cut;
        c = 8'h00;
        cut = (kind == FRAME_CUT) ? $urandom_range(0, 8) : 9;
        for (int p = 0; p < 9; p++) begin
            if (p == cut) begin
                send_request(1'b1, 8'($urandom), 8'($urandom));
                frames_cut++;
                return;
            end
            if (p == 0) begin
                b = lo;
            end else if (p == 1) begin
                b = hi;
            end else if (p < 8) begin
                b = 8'($urandom);
            end else if (kind == FRAME_BAD_CRC) begin
                b = c ^ 8'($urandom_range(1, 255));
            end else begin
                b = c;
            end
            if (p < 8) begin
                c = crc_fold(c, b);
            end
            send_request(1'b0, b, (p == 8) ? knob_last : 8'($urandom));
        end
        if (kind == FRAME_GOOD) begin
            frames_good++;
        end else begin
            frames_bad++;
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= d;
        do @(posedge i_clk); while (!cfg_ch.ready);
    endtask

    task automatic set_config(input int b, input int s, input int h);
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
        write_reg(CFG_IDX_BASE, b[CFG_DATA_W-1:0]);
        write_reg(CFG_IDX_STEP, s[CFG_DATA_W-1:0]);
        write_reg(CFG_IDX_HYST, h[CFG_DATA_W-1:0]);
        cfg_ch.valid <= 1'b0;
        cur_base = b;
        cur_step = s;
        cur_hyst = h;
        settings++;
    endtask

    // Half of the frames carry a reading close to the current setpoint band.
    task automatic pick_word(output logic [7:0] lo, output logic [7:0] hi);
        int t;
        if ($urandom_range(0, 1) == 1) begin
            lo = 8'($urandom);
            hi = 8'($urandom);
        end else begin
            t = cur_base + int'($urandom_range(0, cur_step * 26))
                + int'($urandom_range(0, 2 * cur_hyst + 200)) - cur_hyst - 100;
            t = t * 16 / 100;
            if (t > 2047) begin
                t = 2047;
            end else if (t < -2047) begin
                t = -2047;
            end
            lo = t[7:0];
            hi = t[15:8];
        end
    endtask

    initial begin
        logic [7:0] lo;
        logic [7:0] hi;
        int         r;
        int         n;
        int         next_setting;
        int         total;
        i_rst_n         <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.mode      <= 1'b0;
        in_ch.data_byte <= 8'd0;
        in_ch.knob      <= 8'd0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.index    <= CFG_IDX_BASE;
        cfg_ch.data     <= '0;
        calm         = 1'b0;
        items        = 0;
        frames_good  = 0;
        frames_bad   = 0;
        frames_cut   = 0;
        settings     = 0;
        cur_base     = int'(BASE_RESET);
        cur_step     = int'(STEP_RESET);
        cur_hyst     = int'(HYST_RESET);
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_frame(8'hFF, 8'h7F, 8'd0, FRAME_GOOD);
        send_request(1'b0, 8'h50, 8'h00);
        send_request(1'b1, 8'hFF, 8'hFF);
        send_frame(8'h01, 8'h80, 8'd255, FRAME_GOOD);
        send_frame(8'h00, 8'h80, 8'd255, FRAME_BAD_CRC);

        total = items + RANDOM_ITEMS;
        next_setting = items;
        while (items < total) begin
            if (items >= next_setting) begin
                if (settings == 0) begin
                    set_config(-12800, 0, 0);
                end else if (settings == 1) begin
                    set_config(12800, 255, 2000);
                end else if ($urandom_range(0, 1) == 1) begin
                    set_config(int'($urandom_range(1000, 3000)), $urandom_range(0, 255),
                               $urandom_range(0, 300));
                end else begin
                    set_config(int'($urandom_range(0, 25600)) - 12800, $urandom_range(0, 255),
                               $urandom_range(0, 2000));
                end
                next_setting += 110;
            end
            calm = (items >= total - RANDOM_ITEMS + CALM_FROM)
                && (items < total - RANDOM_ITEMS + CALM_FROM + CALM_LEN);
            r = $urandom_range(0, 99);
            pick_word(lo, hi);
            if (r < 65) begin
                send_frame(lo, hi, 8'($urandom), FRAME_GOOD);
            end else if (r < 77) begin
                send_frame(lo, hi, 8'($urandom), FRAME_BAD_CRC);
            end else if (r < 87) begin
                send_frame(lo, hi, 8'($urandom), FRAME_CUT);
            end else begin
                n = $urandom_range(1, 6);
                repeat (n) send_request($urandom_range(0, 3) == 0, 8'($urandom), 8'($urandom));
                if ($urandom_range(0, 3) != 0) begin
                    send_request(1'b1, 8'($urandom), 8'($urandom));
                end
            end
        end
        calm = 1'b0;

        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (8) @(posedge i_clk);
        $display("Summary: %0d requests sent, %0d results checked over %0d register settings",
                 items, checked, settings);
        $display("Frames: %0d good, %0d with bad CRC, %0d cut short by a missing presence pulse",
                 frames_good, frames_bad, frames_cut);
        if (fails == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+design
design/sfct_pkg.sv
design/sfct_in_if.sv
design/sfct_out_if.sv
design/sfct_cfg_if.sv
design/sfct_cfg_regs.sv
design/sfct_frame.sv
design/sfct_heater.sv
design/sensor_frame_check_thermostat_top.sv
sim/sfct_checker.sv
sim/tb.sv
